[hdl/sas_pkg.sv]
// ----------------------------------------------------------------------------
// sas_pkg
// Shared types, codes and sizes of the suffix array pattern search block.
// ----------------------------------------------------------------------------
`default_nettype none

package sas_pkg;

  // default store depths
  localparam int TEXT_LEN_DEF = 32;
  localparam int PAT_LEN_DEF  = 32;

  // depth of the request queue between front and back
  localparam int QUEUE_DEPTH  = 4;

  // field widths
  localparam int KIND_W = 3;
  localparam int BYTE_W = 8;
  localparam int SUF_W  = 5;
  localparam int POS_W  = 6;

  // request kinds
  localparam logic [KIND_W-1:0] KIND_TEXT   = 3'd0;
  localparam logic [KIND_W-1:0] KIND_SUFFIX = 3'd1;
  localparam logic [KIND_W-1:0] KIND_PAT    = 3'd2;
  localparam logic [KIND_W-1:0] KIND_SEARCH = 3'd3;
  localparam logic [KIND_W-1:0] KIND_CLEAR  = 3'd4;

  // one queued request
  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [BYTE_W-1:0] data_byte;
    logic [SUF_W-1:0]  suffix_index;
  } item_t;

  // front to queue
  typedef struct packed {
    logic  valid;
    item_t item;
  } push_t;

  // queue head towards the back
  typedef struct packed {
    logic  valid;
    item_t item;
  } head_t;

endpackage

`default_nettype wire

[hdl/sas_ram.sv]
// ----------------------------------------------------------------------------
// sas_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module sas_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

[hdl/sas_front.sv]
// ----------------------------------------------------------------------------
// sas_front
// Request intake: takes requests while the queue has room and classifies
// them, dropping kinds that do nothing.
// ----------------------------------------------------------------------------
`default_nettype none

module sas_front (
  input  wire logic                       start,
  input  wire logic                       q_full,
  input  wire logic [sas_pkg::KIND_W-1:0] in_kind,
  input  wire logic [sas_pkg::BYTE_W-1:0] in_data_byte,
  input  wire logic [sas_pkg::SUF_W-1:0]  in_suffix_index,
  output logic                            busy,
  output sas_pkg::push_t                  push
);

  logic accept;
  logic kind_ok;

  // request taken whenever the queue has a free slot
  assign busy   = q_full;
  assign accept = start && !q_full;

  // only the five defined kinds reach the back
  always_comb begin
    kind_ok = in_kind inside {[sas_pkg::KIND_TEXT:sas_pkg::KIND_CLEAR]};
  end

  assign push.valid             = accept && kind_ok;
  assign push.item.kind         = in_kind;
  assign push.item.data_byte    = in_data_byte;
  assign push.item.suffix_index = in_suffix_index;

endmodule

`default_nettype wire

[hdl/sas_queue.sv]
// ----------------------------------------------------------------------------
// sas_queue
// Short request queue between front and back, register based.
// ----------------------------------------------------------------------------
`default_nettype none

module sas_queue #(
  parameter int DEPTH = sas_pkg::QUEUE_DEPTH,
  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1,
  localparam int CNTW = $clog2(DEPTH + 1)
) (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire sas_pkg::push_t push,
  input  wire logic           pop,
  output logic                full,
  output sas_pkg::head_t      head
);

  sas_pkg::item_t  slot_r [DEPTH];
  logic [PW-1:0]   wptr_r, wptr_nxt;
  logic [PW-1:0]   rptr_r, rptr_nxt;
  logic [CNTW-1:0] cnt_r, cnt_nxt;
  logic            do_push;
  logic            do_pop;

  assign full       = (cnt_r == CNTW'(DEPTH));
  assign do_push    = push.valid && !full;
  assign do_pop     = pop && (cnt_r != '0);
  assign head.valid = (cnt_r != '0);
  assign head.item  = slot_r[rptr_r];

  // pointer and fill count update
  always_comb begin
    wptr_nxt = wptr_r;
    rptr_nxt = rptr_r;
    cnt_nxt  = cnt_r;
    if (do_push) begin
      wptr_nxt = (wptr_r == PW'(DEPTH - 1)) ? '0 : wptr_r + PW'(1);
    end
    if (do_pop) begin
      rptr_nxt = (rptr_r == PW'(DEPTH - 1)) ? '0 : rptr_r + PW'(1);
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + CNTW'(1);
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - CNTW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r  <= '0;
    end else begin
      wptr_r <= wptr_nxt;
      rptr_r <= rptr_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  // payload slots
  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wptr_r] <= push.item;
    end
  end

endmodule

`default_nettype wire

[hdl/sas_back.sv]
// ----------------------------------------------------------------------------
// sas_back
// Executes queued requests: store appends, clear, and the search sequencer
// (binary search, bucket widening, per-entry pattern compare).
// ----------------------------------------------------------------------------
`default_nettype none

module sas_back #(
  parameter int TEXT_LEN = sas_pkg::TEXT_LEN_DEF,
  parameter int PAT_LEN  = sas_pkg::PAT_LEN_DEF
) (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire sas_pkg::head_t            head,
  output logic                           pop,
  output logic                           out_strobe,
  output logic [sas_pkg::POS_W-1:0]      out_match_position,
  output logic                           out_found,
  output logic                           out_last
);

  localparam int CW  = $clog2(TEXT_LEN + 1);
  localparam int AW  = $clog2(TEXT_LEN);
  localparam int PCW = $clog2(PAT_LEN + 1);
  localparam int PAW = (PAT_LEN > 1) ? $clog2(PAT_LEN) : 1;
  localparam int M1  = (CW > PCW) ? CW : PCW;
  localparam int LW  = ((M1 > sas_pkg::SUF_W) ? M1 : sas_pkg::SUF_W) + 1;
  localparam int BW  = sas_pkg::BYTE_W;
  localparam int SW  = sas_pkg::SUF_W;
  localparam int OW  = sas_pkg::POS_W;

  // sequencer states
  localparam logic [3:0] ST_IDLE = 4'd0;
  localparam logic [3:0] ST_ZERO = 4'd1;
  localparam logic [3:0] ST_P0   = 4'd2;
  localparam logic [3:0] ST_BCHK = 4'd3;
  localparam logic [3:0] ST_KSUF = 4'd4;
  localparam logic [3:0] ST_KTXT = 4'd5;
  localparam logic [3:0] ST_KKEY = 4'd6;
  localparam logic [3:0] ST_SSUF = 4'd7;
  localparam logic [3:0] ST_SS   = 4'd8;
  localparam logic [3:0] ST_MRD  = 4'd9;
  localparam logic [3:0] ST_MCMP = 4'd10;
  localparam logic [3:0] ST_FIN  = 4'd11;

  // key fetch return codes
  localparam logic [1:0] RET_BIN = 2'd0;
  localparam logic [1:0] RET_LO  = 2'd1;
  localparam logic [1:0] RET_HI  = 2'd2;

  logic [3:0]     state_r, state_nxt;
  logic [1:0]     ret_r, ret_nxt;
  logic           full_r, full_nxt;
  logic [CW-1:0]  tcnt_r, tcnt_nxt;
  logic [CW-1:0]  scnt_r, scnt_nxt;
  logic [PCW-1:0] pcnt_r, pcnt_nxt;
  logic [BW-1:0]  p0_r, p0_nxt;
  logic [CW-1:0]  low_r, low_nxt;
  logic [CW-1:0]  hb_r, hb_nxt;
  logic [AW-1:0]  mid_r, mid_nxt;
  logic [AW-1:0]  kslot_r, kslot_nxt;
  logic [AW-1:0]  lo_r, lo_nxt;
  logic [AW-1:0]  hi_r, hi_nxt;
  logic [AW-1:0]  si_r, si_nxt;
  logic           kval_r, kval_nxt;
  logic [SW-1:0]  ms_r, ms_nxt;
  logic [PAW-1:0] mi_r, mi_nxt;
  logic [SW-1:0]  pend_r, pend_nxt;
  logic           pendv_r, pendv_nxt;
  logic [CW-1:0]  z_r, z_nxt;
  logic           strobe_r, strobe_nxt;
  logic [OW-1:0]  pos_r, pos_nxt;
  logic           found_r, found_nxt;
  logic           last_r, last_nxt;

  // store ports
  logic          txt_we, suf_we, pat_we;
  logic [AW-1:0] txt_raddr, suf_raddr;
  logic [PAW-1:0] pat_raddr;
  logic [BW-1:0] txt_rdata, pat_rdata;
  logic [SW-1:0] suf_rdata;

  // key compare and midpoint
  logic [CW:0]   mid_sum;
  logic [AW-1:0] mid_w;
  logic          key_eq, key_lt;

  assign mid_sum = (CW + 1)'(low_r) + (CW + 1)'(hb_r) - (CW + 1)'(1);
  assign mid_w   = AW'(mid_sum >> 1);
  assign key_eq  = kval_r && (p0_r == txt_rdata);
  assign key_lt  = kval_r && (p0_r < txt_rdata);

  assign pop = (state_r == ST_IDLE) && head.valid;

  // store writes happen only on appends taken in idle
  assign txt_we = pop && (head.item.kind == sas_pkg::KIND_TEXT) &&
                  (tcnt_r < CW'(TEXT_LEN));
  assign suf_we = pop && (head.item.kind == sas_pkg::KIND_SUFFIX) &&
                  (scnt_r < CW'(TEXT_LEN));
  assign pat_we = pop && (head.item.kind == sas_pkg::KIND_PAT) &&
                  (pcnt_r < PCW'(PAT_LEN));

  sas_ram #(.WIDTH(BW), .DEPTH(TEXT_LEN)) u_text (
    .clk   (clk),
    .we    (txt_we),
    .waddr (AW'(tcnt_r)),
    .wdata (head.item.data_byte),
    .raddr (txt_raddr),
    .rdata (txt_rdata)
  );

  sas_ram #(.WIDTH(SW), .DEPTH(TEXT_LEN)) u_suffix (
    .clk   (clk),
    .we    (suf_we),
    .waddr (AW'(scnt_r)),
    .wdata (head.item.suffix_index),
    .raddr (suf_raddr),
    .rdata (suf_rdata)
  );

  sas_ram #(.WIDTH(BW), .DEPTH(PAT_LEN)) u_pattern (
    .clk   (clk),
    .we    (pat_we),
    .waddr (PAW'(pcnt_r)),
    .wdata (head.item.data_byte),
    .raddr (pat_raddr),
    .rdata (pat_rdata)
  );

  // search sequencer
  always_comb begin
    logic start_hi;
    logic start_scan;
    logic scan_next;
    logic m_ok;
    logic m_fail;
    start_hi   = 1'b0;
    start_scan = 1'b0;
    scan_next  = 1'b0;
    m_ok       = 1'b0;
    m_fail     = 1'b0;

    state_nxt  = state_r;
    ret_nxt    = ret_r;
    full_nxt   = full_r;
    tcnt_nxt   = tcnt_r;
    scnt_nxt   = scnt_r;
    pcnt_nxt   = pcnt_r;
    p0_nxt     = p0_r;
    low_nxt    = low_r;
    hb_nxt     = hb_r;
    mid_nxt    = mid_r;
    kslot_nxt  = kslot_r;
    lo_nxt     = lo_r;
    hi_nxt     = hi_r;
    si_nxt     = si_r;
    kval_nxt   = kval_r;
    ms_nxt     = ms_r;
    mi_nxt     = mi_r;
    pend_nxt   = pend_r;
    pendv_nxt  = pendv_r;
    z_nxt      = z_r;
    strobe_nxt = 1'b0;
    pos_nxt    = pos_r;
    found_nxt  = found_r;
    last_nxt   = last_r;
    txt_raddr  = '0;
    suf_raddr  = '0;
    pat_raddr  = '0;

    case (state_r)
      ST_IDLE: begin
        if (pop) begin
          case (head.item.kind)
            sas_pkg::KIND_TEXT: begin
              if (txt_we) tcnt_nxt = tcnt_r + CW'(1);
            end
            sas_pkg::KIND_SUFFIX: begin
              if (suf_we) scnt_nxt = scnt_r + CW'(1);
            end
            sas_pkg::KIND_PAT: begin
              if (pat_we) pcnt_nxt = pcnt_r + PCW'(1);
            end
            sas_pkg::KIND_CLEAR: begin
              tcnt_nxt = '0;
              scnt_nxt = '0;
              pcnt_nxt = '0;
            end
            sas_pkg::KIND_SEARCH: begin
              pendv_nxt = 1'b0;
              if (pcnt_r == '0) begin
                z_nxt     = '0;
                state_nxt = ST_ZERO;
              end else begin
                pat_raddr = '0;
                state_nxt = ST_P0;
              end
            end
            default: ;
          endcase
        end
      end

      // empty pattern lists every position up to the text length
      ST_ZERO: begin
        strobe_nxt = 1'b1;
        pos_nxt    = OW'(z_r);
        found_nxt  = 1'b1;
        last_nxt   = (z_r == tcnt_r);
        if (z_r == tcnt_r) begin
          state_nxt = ST_IDLE;
        end else begin
          z_nxt = z_r + CW'(1);
        end
      end

      // first pattern byte arrives, pick the search mode
      ST_P0: begin
        p0_nxt = pat_rdata;
        if (LW'(pcnt_r) == LW'(tcnt_r)) begin
          full_nxt  = 1'b1;
          ms_nxt    = '0;
          mi_nxt    = '0;
          state_nxt = ST_MRD;
        end else begin
          full_nxt = 1'b0;
          if (scnt_r == '0) begin
            state_nxt = ST_FIN;
          end else begin
            low_nxt   = '0;
            hb_nxt    = scnt_r;
            state_nxt = ST_BCHK;
          end
        end
      end

      // binary search probe, bounds held as [low, hb)
      ST_BCHK: begin
        if (low_r >= hb_r) begin
          state_nxt = ST_FIN;
        end else begin
          mid_nxt   = mid_w;
          kslot_nxt = mid_w;
          ret_nxt   = RET_BIN;
          state_nxt = ST_KSUF;
        end
      end

      // key fetch: suffix entry, then its first text byte
      ST_KSUF: begin
        suf_raddr = kslot_r;
        state_nxt = ST_KTXT;
      end

      ST_KTXT: begin
        kval_nxt  = LW'(suf_rdata) < LW'(tcnt_r);
        txt_raddr = AW'(suf_rdata);
        state_nxt = ST_KKEY;
      end

      ST_KKEY: begin
        case (ret_r)
          RET_BIN: begin
            if (key_eq) begin
              lo_nxt = mid_r;
              hi_nxt = mid_r;
              if (mid_r != '0) begin
                kslot_nxt = mid_r - AW'(1);
                ret_nxt   = RET_LO;
                state_nxt = ST_KSUF;
              end else begin
                start_hi = 1'b1;
              end
            end else begin
              if (key_lt) begin
                hb_nxt = CW'(mid_r);
              end else begin
                low_nxt = CW'(mid_r) + CW'(1);
              end
              state_nxt = ST_BCHK;
            end
          end
          RET_LO: begin
            if (key_eq) begin
              lo_nxt = kslot_r;
              if (kslot_r != '0) begin
                kslot_nxt = kslot_r - AW'(1);
                state_nxt = ST_KSUF;
              end else begin
                start_hi = 1'b1;
              end
            end else begin
              start_hi = 1'b1;
            end
          end
          RET_HI: begin
            if (key_eq) begin
              hi_nxt = kslot_r;
              if ((CW'(kslot_r) + CW'(1)) < scnt_r) begin
                kslot_nxt = kslot_r + AW'(1);
                state_nxt = ST_KSUF;
              end else begin
                start_scan = 1'b1;
              end
            end else begin
              start_scan = 1'b1;
            end
          end
          default: state_nxt = ST_FIN;
        endcase
        // upper widening starts one past the probe hit
        if (start_hi) begin
          if ((CW'(mid_r) + CW'(1)) < scnt_r) begin
            kslot_nxt = mid_r + AW'(1);
            ret_nxt   = RET_HI;
            state_nxt = ST_KSUF;
          end else begin
            start_scan = 1'b1;
          end
        end
        if (start_scan) begin
          si_nxt    = lo_nxt;
          state_nxt = ST_SSUF;
        end
      end

      // bucket scan in suffix order
      ST_SSUF: begin
        suf_raddr = si_r;
        state_nxt = ST_SS;
      end

      ST_SS: begin
        ms_nxt = suf_rdata;
        mi_nxt = '0;
        if ((LW'(suf_rdata) + LW'(pcnt_r)) > LW'(tcnt_r)) begin
          scan_next = 1'b1;
        end else begin
          state_nxt = ST_MRD;
        end
      end

      // byte-by-byte pattern compare at position ms
      ST_MRD: begin
        txt_raddr = AW'(LW'(ms_r) + LW'(mi_r));
        pat_raddr = mi_r;
        state_nxt = ST_MCMP;
      end

      ST_MCMP: begin
        if (txt_rdata != pat_rdata) begin
          m_fail = 1'b1;
        end else if ((PCW'(mi_r) + PCW'(1)) == pcnt_r) begin
          m_ok = 1'b1;
        end else begin
          mi_nxt    = mi_r + PAW'(1);
          state_nxt = ST_MRD;
        end
        if (full_r) begin
          if (m_ok) begin
            strobe_nxt = 1'b1;
            pos_nxt    = '0;
            found_nxt  = 1'b1;
            last_nxt   = 1'b1;
            state_nxt  = ST_IDLE;
          end else if (m_fail) begin
            state_nxt = ST_FIN;
          end
        end else begin
          // a hit is held back one step so the final one can carry last
          if (m_ok) begin
            if (pendv_r) begin
              strobe_nxt = 1'b1;
              pos_nxt    = OW'(pend_r);
              found_nxt  = 1'b1;
              last_nxt   = 1'b0;
            end
            pend_nxt  = ms_r;
            pendv_nxt = 1'b1;
          end
          scan_next = m_ok || m_fail;
        end
      end

      // final result: held hit or not-found
      ST_FIN: begin
        strobe_nxt = 1'b1;
        pos_nxt    = pendv_r ? OW'(pend_r) : '0;
        found_nxt  = pendv_r;
        last_nxt   = 1'b1;
        pendv_nxt  = 1'b0;
        state_nxt  = ST_IDLE;
      end

      default: state_nxt = ST_IDLE;
    endcase

    // step to the next bucket entry or finish
    if (scan_next) begin
      if (si_r == hi_r) begin
        state_nxt = ST_FIN;
      end else begin
        si_nxt    = si_r + AW'(1);
        state_nxt = ST_SSUF;
      end
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      tcnt_r   <= '0;
      scnt_r   <= '0;
      pcnt_r   <= '0;
      pendv_r  <= 1'b0;
      strobe_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      tcnt_r   <= tcnt_nxt;
      scnt_r   <= scnt_nxt;
      pcnt_r   <= pcnt_nxt;
      pendv_r  <= pendv_nxt;
      strobe_r <= strobe_nxt;
    end
  end

  // working and payload registers
  always_ff @(posedge clk) begin
    ret_r   <= ret_nxt;
    full_r  <= full_nxt;
    p0_r    <= p0_nxt;
    low_r   <= low_nxt;
    hb_r    <= hb_nxt;
    mid_r   <= mid_nxt;
    kslot_r <= kslot_nxt;
    lo_r    <= lo_nxt;
    hi_r    <= hi_nxt;
    si_r    <= si_nxt;
    kval_r  <= kval_nxt;
    ms_r    <= ms_nxt;
    mi_r    <= mi_nxt;
    pend_r  <= pend_nxt;
    z_r     <= z_nxt;
    pos_r   <= pos_nxt;
    found_r <= found_nxt;
    last_r  <= last_nxt;
  end

  assign out_strobe         = strobe_r;
  assign out_match_position = pos_r;
  assign out_found          = found_r;
  assign out_last           = last_r;

endmodule

`default_nettype wire

[hdl/suffix_array_pattern_search.sv]
// ----------------------------------------------------------------------------
// suffix_array_pattern_search
// Loads text, suffix array and pattern stores and reports every text
// position where the pattern occurs.
// ----------------------------------------------------------------------------
//
//  channel   handshake             ports
//  request   start & !busy         in_kind, in_data_byte, in_suffix_index
//  result    out_strobe, 1 cycle   out_match_position, out_found, out_last
//
//  requests go into a four-entry queue; busy is high only when it is full
//  appends and clear are done by the back end in idle; unused kinds are dropped at intake
//  empty-pattern search lists every position up to the text length; a pattern as
//  long as the text is compared directly; otherwise binary search probes, bucket
//  widening probes, a bucket scan and byte compares, set by the single read port per store
//  synchronous reset clears counts and queue; the receiver cannot stall
//
`default_nettype none

module suffix_array_pattern_search #(
  parameter int TEXT_LEN = sas_pkg::TEXT_LEN_DEF,
  parameter int PAT_LEN  = sas_pkg::PAT_LEN_DEF
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        start,
  output logic                             busy,
  input  wire logic [sas_pkg::KIND_W-1:0]  in_kind,
  input  wire logic [sas_pkg::BYTE_W-1:0]  in_data_byte,
  input  wire logic [sas_pkg::SUF_W-1:0]   in_suffix_index,
  output logic                             out_strobe,
  output logic [sas_pkg::POS_W-1:0]        out_match_position,
  output logic                             out_found,
  output logic                             out_last
);

  sas_pkg::push_t push;
  sas_pkg::head_t head;
  logic           q_full;
  logic           pop;

  // intake and classification
  sas_front u_front (
    .start           (start),
    .q_full          (q_full),
    .in_kind         (in_kind),
    .in_data_byte    (in_data_byte),
    .in_suffix_index (in_suffix_index),
    .busy            (busy),
    .push            (push)
  );

  // request queue
  sas_queue #(.DEPTH(sas_pkg::QUEUE_DEPTH)) u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (push),
    .pop   (pop),
    .full  (q_full),
    .head  (head)
  );

  // execution
  sas_back #(.TEXT_LEN(TEXT_LEN), .PAT_LEN(PAT_LEN)) u_back (
    .clk                (clk),
    .rst_n              (rst_n),
    .head               (head),
    .pop                (pop),
    .out_strobe         (out_strobe),
    .out_match_position (out_match_position),
    .out_found          (out_found),
    .out_last           (out_last)
  );

  // not-found result closes the search at position zero
  a_notfound_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && !out_found) |-> (out_last && (out_match_position == '0)))
    else $error("not-found result without last or with a position");

  // reported positions never pass the text capacity
  a_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> ({1'b0, out_match_position} <= 7'(TEXT_LEN)))
    else $error("match position beyond text capacity");

  // a request is only dequeued when the queue holds one
  a_pop_when_free: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> head.valid)
    else $error("dequeue from an empty queue");

  // a full queue holds busy until something leaves it
  a_busy_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (busy && !pop) |=> busy)
    else $error("busy dropped without a dequeue");

endmodule

`default_nettype wire
